FILE: design/bcd_pkg.sv
// Shared types, codes and arithmetic helpers for the block texture decoder.
package bcd_pkg;

  // block_format codes; code 3 decodes as BC3
  localparam logic [1:0] FMT_BC1 = 2'd0;
  localparam logic [1:0] FMT_BC2 = 2'd1;
  localparam logic [1:0] FMT_BC3 = 2'd2;

  // register index bit of the byte address
  localparam logic REG_BLOCK_FORMAT = 1'b0;

  localparam logic [1:0] LAST_ROW_IDX = 2'd3;

  typedef struct packed {
    logic [63:0] colour_block;
    logic [63:0] alpha_block;
  } bcd_in_t;

  typedef struct packed {
    logic [1:0]  row_index;
    logic [31:0] texel_left;
    logic [31:0] texel_second;
    logic [31:0] texel_third;
    logic [31:0] texel_right;
    logic        last_row;
  } bcd_out_t;

  // blue in the high byte so that {alpha, rgb} packs red at bits 7:0
  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } rgb_t;

  typedef struct packed {
    logic [1:0]       fmt;
    rgb_t [3:0]       col;
    logic [3:0]       opq;
    logic [7:0][7:0]  apal;
    logic [31:0]      cidx;
    logic [63:0]      abits;
  } pal_t;

  // per-texel selectors handed to one lane
  typedef struct packed {
    logic [1:0] ci;
    logic [3:0] nib;
    logic [2:0] ai;
  } lane_sel_t;

  function automatic rgb_t expand565(input logic [15:0] v);
    rgb_t c;
    c.red   = {v[15:11], v[15:13]};
    c.green = {v[10:5], v[10:9]};
    c.blue  = {v[4:0], v[4:2]};
    return c;
  endfunction

  // floor(x/3) for x <= 765 via reciprocal 683/2048
  function automatic logic [7:0] div3(input logic [9:0] x);
    logic [19:0] p;
    p = 20'(x) * 20'd683;
    return p[18:11];
  endfunction

  // floor(x/5) for x <= 1275 via reciprocal 52429/2^18
  function automatic logic [7:0] div5(input logic [10:0] x);
    logic [26:0] p;
    p = 27'(x) * 27'd52429;
    return p[25:18];
  endfunction

  // floor(x/7) for x <= 1785 via reciprocal 9363/2^16
  function automatic logic [7:0] div7(input logic [10:0] x);
    logic [24:0] p;
    p = 25'(x) * 25'd9363;
    return p[23:16];
  endfunction

endpackage

FILE: design/bcd_palette.sv
// Palette stage: builds colour and alpha palettes of one block and registers them.
module bcd_palette (
  input  logic            clk,
  input  logic            load,
  input  logic [1:0]      fmt,
  input  bcd_pkg::bcd_in_t blk,
  output bcd_pkg::pal_t   pal
);

  bcd_pkg::pal_t pal_r;
  bcd_pkg::pal_t pal_nxt;

  logic [15:0]      e0;
  logic [15:0]      e1;
  logic             three;
  bcd_pkg::rgb_t    c0;
  bcd_pkg::rgb_t    c1;
  bcd_pkg::rgb_t    cm2;
  bcd_pkg::rgb_t    cm3;
  logic [7:0]       a0;
  logic [7:0]       a1;
  logic [10:0]      ws;

  assign e0 = blk.colour_block[15:0];
  assign e1 = blk.colour_block[31:16];
  assign three = (fmt == bcd_pkg::FMT_BC1) && (e0 <= e1);
  assign c0 = bcd_pkg::expand565(e0);
  assign c1 = bcd_pkg::expand565(e1);
  assign a0 = blk.alpha_block[7:0];
  assign a1 = blk.alpha_block[15:8];

  always_comb begin
    cm2 = '0;
    cm3 = '0;
    if (three) begin
      cm2.red   = 8'((({1'b0, c0.red}   + {1'b0, c1.red})   >> 1));
      cm2.green = 8'((({1'b0, c0.green} + {1'b0, c1.green}) >> 1));
      cm2.blue  = 8'((({1'b0, c0.blue}  + {1'b0, c1.blue})  >> 1));
    end else begin
      cm2.red   = bcd_pkg::div3({1'b0, c0.red, 1'b0}   + {2'b0, c1.red});
      cm2.green = bcd_pkg::div3({1'b0, c0.green, 1'b0} + {2'b0, c1.green});
      cm2.blue  = bcd_pkg::div3({1'b0, c0.blue, 1'b0}  + {2'b0, c1.blue});
      cm3.red   = bcd_pkg::div3({2'b0, c0.red}   + {1'b0, c1.red, 1'b0});
      cm3.green = bcd_pkg::div3({2'b0, c0.green} + {1'b0, c1.green, 1'b0});
      cm3.blue  = bcd_pkg::div3({2'b0, c0.blue}  + {1'b0, c1.blue, 1'b0});
    end
  end

  always_comb begin
    ws = '0;
    pal_nxt.fmt    = fmt;
    pal_nxt.col[0] = c0;
    pal_nxt.col[1] = c1;
    pal_nxt.col[2] = cm2;
    pal_nxt.col[3] = cm3;
    pal_nxt.opq    = {!three, 3'b111};
    pal_nxt.cidx   = blk.colour_block[63:32];
    pal_nxt.abits  = blk.alpha_block;
    pal_nxt.apal   = '0;
    pal_nxt.apal[0] = a0;
    pal_nxt.apal[1] = a1;
    if (a0 <= a1) begin
      for (int i = 1; i < 5; i++) begin
        ws = 11'(5 - i) * {3'b0, a0} + 11'(i) * {3'b0, a1};
        pal_nxt.apal[1 + i] = bcd_pkg::div5(ws);
      end
      pal_nxt.apal[6] = 8'd0;
      pal_nxt.apal[7] = 8'd255;
    end else begin
      for (int i = 1; i < 7; i++) begin
        ws = 11'(7 - i) * {3'b0, a0} + 11'(i) * {3'b0, a1};
        pal_nxt.apal[1 + i] = bcd_pkg::div7(ws);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pal_r <= pal_nxt;
    end
  end

  assign pal = pal_r;

endmodule

FILE: design/bcd_lane.sv
// Texel lane: looks up colour and alpha of one texel from the block palettes.
module bcd_lane (
  input  bcd_pkg::pal_t     pal,
  input  bcd_pkg::lane_sel_t sel,
  output logic [31:0]       texel
);

  bcd_pkg::rgb_t rgb;
  logic [7:0]    alpha;

  assign rgb = pal.col[sel.ci];

  always_comb begin
    unique case (pal.fmt)
      bcd_pkg::FMT_BC1: alpha = pal.opq[sel.ci] ? 8'd255 : 8'd0;
      bcd_pkg::FMT_BC2: alpha = {sel.nib, sel.nib};
      default:          alpha = pal.apal[sel.ai];
    endcase
  end

  assign texel = {alpha, rgb};

endmodule

FILE: design/bc_block_texture_decoder_core.sv
// Top level of the BC1/BC2/BC3 block decoder: handshake, row sequencing and row merge.
//
// Usage: present a compressed 4x4 block on in_data and raise start; the block is
// taken at a rising edge where start is high and busy is low. in_data carries the
// 64-bit colour half and the 64-bit alpha half, both little-endian.
// Each block yields four beats on out_data, rows 0 to 3 in order on consecutive
// cycles, each marked by out_strobe for exactly one cycle; last_row flags row 3.
// Four lanes decode the four texels of a row in parallel and a merge register
// assembles the row, so one row leaves per cycle.
// A block passes the input register, the palette register and the merge register
// before row 0 shows on out_data. Block throughput is bounded by the four rows
// each block emits; a second block may be taken while the first is in the
// palette stage, and busy holds later blocks off until the last row starts.
// The receiver cannot stall: every strobed beat is taken.
// block_format sits at APB byte address 0 (0 BC1, 1 BC2, 2 BC3) and must only be
// written while the block is idle; it is sampled with each accepted block.
// Reset (rst_n low, synchronous) drops any block in flight and sets BC1.
module bc_block_texture_decoder_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  bcd_pkg::bcd_in_t  in_data,
  output logic              out_strobe,
  output bcd_pkg::bcd_out_t out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [1:0]        fmt_cfg_r;
  logic              v1_r;
  logic              v1_nxt;
  logic              v2_r;
  logic              v2_nxt;
  logic [1:0]        row_r;
  logic [1:0]        row_nxt;
  bcd_pkg::bcd_in_t  blk_r;
  logic [1:0]        blk_fmt_r;
  logic              out_strobe_r;
  bcd_pkg::bcd_out_t out_r;
  bcd_pkg::bcd_out_t out_nxt;

  logic              accept;
  logic              last2;
  logic              load2;
  logic              cfg_wr;
  bcd_pkg::pal_t     pal;
  logic [7:0]        row_cidx;
  logic [15:0]       row_nibs;
  logic [11:0]       row_aidx;
  bcd_pkg::lane_sel_t [3:0] sel;
  logic [3:0][31:0]  texel;

  // config port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == bcd_pkg::REG_BLOCK_FORMAT);
  assign prdata = (paddr[2] == bcd_pkg::REG_BLOCK_FORMAT) ? {30'b0, fmt_cfg_r} : 32'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_cfg_r <= bcd_pkg::FMT_BC1;
    end else if (cfg_wr) begin
      fmt_cfg_r <= pwdata[1:0];
    end
  end

  // stage 1 moves into the palette stage when that is empty or on its last row
  assign last2  = v2_r && (row_r == bcd_pkg::LAST_ROW_IDX);
  assign load2  = v1_r && (!v2_r || last2);
  assign busy   = v1_r && !load2;
  assign accept = start && !busy;

  always_comb begin
    v1_nxt = v1_r;
    if (accept) begin
      v1_nxt = 1'b1;
    end else if (load2) begin
      v1_nxt = 1'b0;
    end
    v2_nxt = v2_r;
    if (load2) begin
      v2_nxt = 1'b1;
    end else if (last2) begin
      v2_nxt = 1'b0;
    end
    row_nxt = row_r;
    if (load2) begin
      row_nxt = 2'd0;
    end else if (v2_r) begin
      row_nxt = row_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r         <= 1'b0;
      v2_r         <= 1'b0;
      row_r        <= 2'd0;
      out_strobe_r <= 1'b0;
    end else begin
      v1_r         <= v1_nxt;
      v2_r         <= v2_nxt;
      row_r        <= row_nxt;
      out_strobe_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      blk_r     <= in_data;
      blk_fmt_r <= fmt_cfg_r;
    end
  end

  bcd_palette u_palette (
    .clk  (clk),
    .load (load2),
    .fmt  (blk_fmt_r),
    .blk  (blk_r),
    .pal  (pal)
  );

  // pick the current row's index bits
  assign row_cidx = pal.cidx[{row_r, 3'b000} +: 8];
  assign row_nibs = pal.abits[{row_r, 4'b0000} +: 16];
  assign row_aidx = pal.abits[6'd16 + 6'(row_r) * 6'd12 +: 12];

  for (genvar t = 0; t < 4; t++) begin : g_lane
    assign sel[t].ci  = row_cidx[2 * t +: 2];
    assign sel[t].nib = row_nibs[4 * t +: 4];
    assign sel[t].ai  = row_aidx[3 * t +: 3];

    bcd_lane u_lane (
      .pal   (pal),
      .sel   (sel[t]),
      .texel (texel[t])
    );
  end

  // merge the lanes into one row beat
  always_comb begin
    out_nxt.row_index    = row_r;
    out_nxt.texel_left   = texel[0];
    out_nxt.texel_second = texel[1];
    out_nxt.texel_third  = texel[2];
    out_nxt.texel_right  = texel[3];
    out_nxt.last_row     = (row_r == bcd_pkg::LAST_ROW_IDX);
  end

  always_ff @(posedge clk) begin
    if (v2_r) begin
      out_r <= out_nxt;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_r;

endmodule
